[src/qedr_pkg.sv]
// ----------------------------------------------------------------------------
// qedr_pkg: shared definitions for the quadrature encoder delta reporter
// Holds the accumulator width, the register reset value, the sample type and
// the helper functions used for decoding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package qedr_pkg;

  // Width of the signed step accumulator (legal range 4 to 32).
  localparam int SUM_WIDTH = 16;

  // Widths fixed by the interface.
  localparam int INTERVAL_WIDTH = 10;
  localparam int DELTA_WIDTH    = 16;

  // Reset value of the flush interval register, in milliseconds.
  localparam logic [INTERVAL_WIDTH-1:0] FLUSH_RESET = INTERVAL_WIDTH'(20);

  // Limits of the accumulator and of the reported delta.
  localparam int SUM_MAX   = (2 ** (SUM_WIDTH - 1)) - 1;
  localparam int SUM_MIN   = -(2 ** (SUM_WIDTH - 1));
  localparam int DELTA_MAX = (2 ** (DELTA_WIDTH - 1)) - 1;
  localparam int DELTA_MIN = -(2 ** (DELTA_WIDTH - 1));

  // Step direction for one phase transition.
  typedef enum logic [1:0] {
    STEP_NONE = 2'b00,
    STEP_UP   = 2'b01,
    STEP_DOWN = 2'b10
  } step_t;

  // One registered poll of the encoder pins.
  typedef struct packed {
    logic [1:0] phase;  // {A, B}
    logic       tick;
  } sample_t;

  // Result of one pass through the tracker.
  typedef struct packed {
    logic                         emit;
    logic signed [DELTA_WIDTH-1:0] delta;
  } report_t;

  // Gray-code transition decoder, x4 resolution. Double-bit jumps count as
  // no movement.
  function automatic step_t decode_step(input logic [1:0] from, input logic [1:0] to);
    step_t dir;
    dir = STEP_NONE;
    case ({from, to})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = STEP_UP;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: dir = STEP_DOWN;
      default:                            dir = STEP_NONE;
    endcase
    return dir;
  endfunction

  // Clamp the accumulator to the range of the output field.
  function automatic logic signed [DELTA_WIDTH-1:0] clamp_delta(
      input logic signed [SUM_WIDTH-1:0] sum);
    int s;
    s = int'(sum);
    if (s > DELTA_MAX) begin
      s = DELTA_MAX;
    end
    if (s < DELTA_MIN) begin
      s = DELTA_MIN;
    end
    return DELTA_WIDTH'(s);
  endfunction

endpackage

`default_nettype wire

[src/quadrature_encoder_delta_reporter.sv]
// ----------------------------------------------------------------------------
// quadrature_encoder_delta_reporter: x4 quadrature decoder with timed reports
// Accumulates encoder steps from polled A/B levels and reports the net count
// once per flush interval of millisecond ticks, when it is nonzero.
// ----------------------------------------------------------------------------
// Each input transaction is one poll of the A and B pins plus a flag that one
// millisecond has passed. The block decodes the Gray-code transition against
// the previous poll (+1, -1, or 0 for no change or a double-bit jump), adds it
// to a saturating signed accumulator, and counts ticks. When the tick count
// reaches flush_interval it restarts, and a nonzero accumulator is sent out as
// one delta transaction and cleared. The first poll after reset only captures
// the phase; its tick is still counted. A flush_interval of 0 behaves as 1.
// Timing: a poll is registered at acceptance and processed in the following
// cycle, when its delta (if any) is loaded into the output register, unless
// that register holds a delta that is not taken in that cycle. One poll is
// taken every cycle while in_ready is high; in_ready drops only while the
// output register holds a delta that is not yet taken and the input register
// is also full. The configuration channel is always ready and must be
// written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_delta_reporter (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Poll channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 phase_a,
  input  wire logic                                 phase_b,
  input  wire logic                                 tick,
  // Report channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [qedr_pkg::DELTA_WIDTH-1:0]   delta,
  // Configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [qedr_pkg::INTERVAL_WIDTH-1:0]  flush_interval
);

  logic [qedr_pkg::INTERVAL_WIDTH-1:0] interval;
  qedr_pkg::sample_t                   sample;
  logic                                in_full;
  logic                                advance;
  qedr_pkg::report_t                   report;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= qedr_pkg::FLUSH_RESET;
    end else if (cfg_valid) begin
      interval <= flush_interval;
    end
  end

  // The registered poll moves on whenever the output register is free or is
  // being emptied in this same cycle.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample.phase <= {phase_a, phase_b};
      sample.tick  <= tick;
    end
  end

  qedr_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .sample         (sample),
    .flush_interval (interval),
    .report         (report)
  );

  // Output register: loaded on every advance, holding a transaction only
  // when the processed poll produced a report.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= report.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && report.emit) begin
      delta <= report.delta;
    end
  end

endmodule

`default_nettype wire

[src/qedr_tracker.sv]
// ----------------------------------------------------------------------------
// qedr_tracker: phase decoder, step accumulator and flush timer
// Updates the encoder state for one registered sample per advance strobe and
// returns the report that the sample causes.
// ----------------------------------------------------------------------------
`default_nettype none

module qedr_tracker (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  advance,
  input  wire qedr_pkg::sample_t                     sample,
  input  wire logic [qedr_pkg::INTERVAL_WIDTH-1:0]   flush_interval,
  output qedr_pkg::report_t                          report
);

  logic [1:0]                               prev_phase;
  logic                                     primed;
  logic signed [qedr_pkg::SUM_WIDTH-1:0]    step_sum;
  logic [qedr_pkg::INTERVAL_WIDTH-1:0]      tick_count;

  logic signed [qedr_pkg::SUM_WIDTH-1:0]    step_sum_next;
  logic [qedr_pkg::INTERVAL_WIDTH-1:0]      tick_count_next;
  logic signed [qedr_pkg::SUM_WIDTH-1:0]    acc;
  logic signed [qedr_pkg::SUM_WIDTH:0]      acc_wide;
  logic [qedr_pkg::INTERVAL_WIDTH:0]        count_inc;
  qedr_pkg::step_t                          dir;
  logic                                     flush;

  always_comb begin
    dir      = qedr_pkg::decode_step(prev_phase, sample.phase);
    acc_wide = {step_sum[qedr_pkg::SUM_WIDTH-1], step_sum};
    if (primed) begin
      case (dir)
        qedr_pkg::STEP_UP:   acc_wide = acc_wide + (qedr_pkg::SUM_WIDTH+1)'(1);
        qedr_pkg::STEP_DOWN: acc_wide = acc_wide - (qedr_pkg::SUM_WIDTH+1)'(1);
        default:             acc_wide = acc_wide;
      endcase
    end
    // A single step can leave the range by one at most, so the two top bits
    // show the overflow direction.
    if (acc_wide[qedr_pkg::SUM_WIDTH] != acc_wide[qedr_pkg::SUM_WIDTH-1]) begin
      acc = acc_wide[qedr_pkg::SUM_WIDTH] ? qedr_pkg::SUM_WIDTH'(qedr_pkg::SUM_MIN)
                                          : qedr_pkg::SUM_WIDTH'(qedr_pkg::SUM_MAX);
    end else begin
      acc = acc_wide[qedr_pkg::SUM_WIDTH-1:0];
    end

    count_inc = {1'b0, tick_count} + (qedr_pkg::INTERVAL_WIDTH+1)'(1);
    flush     = sample.tick && (count_inc >= {1'b0, flush_interval});

    report.emit  = flush && (acc != '0);
    report.delta = qedr_pkg::clamp_delta(acc);

    step_sum_next   = flush ? '0 : acc;
    tick_count_next = tick_count;
    if (sample.tick) begin
      tick_count_next = flush ? '0 : count_inc[qedr_pkg::INTERVAL_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase <= '0;
      primed     <= 1'b0;
      step_sum   <= '0;
      tick_count <= '0;
    end else if (advance) begin
      prev_phase <= sample.phase;
      primed     <= 1'b1;
      step_sum   <= step_sum_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

[src/qedr_checker.sv]
// ----------------------------------------------------------------------------
// qedr_checker: port-level checks for the quadrature encoder delta reporter
// Watches the top-level handshakes and the reported delta over time.
// ----------------------------------------------------------------------------
`default_nettype none

module qedr_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [qedr_pkg::DELTA_WIDTH-1:0] delta
);

  // A stalled report transaction keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(delta))
    else $error("report changed while stalled");

  // A zero delta is never reported.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> delta != '0)
    else $error("zero delta reported");

  // The poll channel only backs up behind a stalled report.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("poll channel stalled without a pending report");

  // Reset leaves no report pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("report pending after reset");

endmodule

bind quadrature_encoder_delta_reporter qedr_checker u_qedr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .delta     (delta)
);

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for quadrature_encoder_delta_reporter
// Drives encoder polls through the valid/ready poll channel and tracks the
// decoder state in a local tracker model. Every delta transaction that the
// block sends is checked in order against the tracker's expected deltas.
// ----------------------------------------------------------------------------

module tb;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 5;
  // The block holds at most one poll and one delta in flight; this margin covers them.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int MAX_GAP      = 8;
  localparam int MAX_STALL    = 30;
  localparam int MAX_REPORTS  = 100;
  localparam int RANDOM_PHASES   = 8;
  localparam int POLLS_PER_PHASE = 100;

  // Transition codes {previous, current} that count one step forward or
  // backward. Bit n of each mask stands for code n.
  localparam logic [15:0] FORWARD_CODES = 16'b0100_0001_1000_0010;
  localparam logic [15:0] REVERSE_CODES = 16'b0010_1000_0001_0100;

  typedef enum int {
    RP_ALWAYS,
    RP_COIN,
    RP_SPARSE,
    RP_LONG
  } ready_pattern_t;

  // Clock and every block input start at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic phase_a = 1'b0;
  logic phase_b = 1'b0;
  logic tick = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [qedr_pkg::INTERVAL_WIDTH-1:0] flush_interval = qedr_pkg::FLUSH_RESET;

  logic in_ready;
  logic out_valid;
  logic cfg_ready;
  logic signed [qedr_pkg::DELTA_WIDTH-1:0] delta;

  // Tracker state, mirroring what the block holds after reset.
  logic [1:0]                              trk_prev     = 2'b00;
  bit                                      trk_primed   = 1'b0;
  logic signed [qedr_pkg::SUM_WIDTH-1:0]   trk_sum      = '0;
  logic [qedr_pkg::INTERVAL_WIDTH-1:0]     trk_ticks    = '0;
  logic [qedr_pkg::INTERVAL_WIDTH-1:0]     trk_interval = qedr_pkg::FLUSH_RESET;

  // Deltas the tracker has predicted that the block has not yet sent.
  logic signed [qedr_pkg::DELTA_WIDTH-1:0] pending_deltas[$];
  logic signed [qedr_pkg::DELTA_WIDTH-1:0] expected_delta;

  int   error_count  = 0;
  bit   sender_idles = 1'b1;
  int   burst_left   = 0;
  logic [1:0] cur_phase = 2'b00;

  ready_pattern_t ready_pattern = RP_ALWAYS;
  int   pattern_left = 0;
  int   hold_left    = 0;
  int   sparse_count = 0;

  quadrature_encoder_delta_reporter uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .phase_a        (phase_a),
    .phase_b        (phase_b),
    .tick           (tick),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .delta          (delta),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .flush_interval (flush_interval)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Advances the tracker by one accepted poll. Returns 1 when the poll
  // flushes a nonzero accumulator, with the reported value in d.
  function automatic bit advance_tracker(input logic [1:0] cur, input bit tk,
      output logic signed [qedr_pkg::DELTA_WIDTH-1:0] d);
    logic [3:0]                        code;
    longint                            sum;
    logic [qedr_pkg::INTERVAL_WIDTH:0] next_count;
    bit                                emit;
    emit = 1'b0;
    d    = '0;
    code = {trk_prev, cur};
    // The first poll after reset only captures the phase.
    if (!trk_primed) begin
      trk_primed = 1'b1;
    end else begin
      sum = longint'(trk_sum);
      if (FORWARD_CODES[code]) begin
        sum = sum + 1;
      end else if (REVERSE_CODES[code]) begin
        sum = sum - 1;
      end
      if (sum > qedr_pkg::SUM_MAX) begin
        sum = qedr_pkg::SUM_MAX;
      end
      if (sum < qedr_pkg::SUM_MIN) begin
        sum = qedr_pkg::SUM_MIN;
      end
      trk_sum = qedr_pkg::SUM_WIDTH'(sum);
    end
    trk_prev = cur;
    // Ticks are counted after the step, so a step and a flush can share a
    // poll. An interval of zero flushes on every tick, the same as one.
    if (tk) begin
      next_count = trk_ticks + 1'b1;
      if (next_count >= trk_interval) begin
        trk_ticks = '0;
        if (trk_sum != 0) begin
          sum = longint'(trk_sum);
          if (sum > qedr_pkg::DELTA_MAX) begin
            sum = qedr_pkg::DELTA_MAX;
          end
          if (sum < qedr_pkg::DELTA_MIN) begin
            sum = qedr_pkg::DELTA_MIN;
          end
          d       = qedr_pkg::DELTA_WIDTH'(sum);
          emit    = 1'b1;
          trk_sum = '0;
        end
      end else begin
        trk_ticks = next_count[qedr_pkg::INTERVAL_WIDTH-1:0];
      end
    end
    return emit;
  endfunction

  // Next Gray-code phase {A, B} when the shaft turns by one step.
  function automatic logic [1:0] rotate(input logic [1:0] p,
                                        input qedr_pkg::step_t dir);
    logic [1:0] q;
    case (dir)
      qedr_pkg::STEP_UP:   q = {p[0], ~p[1]};
      qedr_pkg::STEP_DOWN: q = {~p[0], p[1]};
      default:             q = p;
    endcase
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  // Sends one poll transaction. When sender_idles is set the sender works in
  // bursts; between bursts valid drops for a random gap. Valid is only lowered
  // at a step in which it is not raised again.
  task automatic send_poll(input logic [1:0] ph, input bit tk);
    logic signed [qedr_pkg::DELTA_WIDTH-1:0] d;
    if (sender_idles && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    phase_a  <= ph[1];
    phase_b  <= ph[0];
    tick     <= tk;
    do @(posedge clk); while (!in_ready);
    // The transaction was accepted at this edge.
    if (advance_tracker(ph, tk, d)) begin
      pending_deltas.push_back(d);
    end
    cur_phase = ph;
  endtask

  task automatic send_step(input qedr_pkg::step_t dir, input bit tk);
    send_poll(rotate(cur_phase, dir), tk);
  endtask

  // Holds the sender off until every predicted delta has been received.
  task automatic await_deltas();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_deltas.size() != 0) @(posedge clk);
  endtask

  // Idle point: nothing expected, and polls that cause no delta have had
  // time to leave the pipeline.
  task automatic settle();
    await_deltas();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [qedr_pkg::INTERVAL_WIDTH-1:0] v);
    settle();
    cfg_valid      <= 1'b1;
    flush_interval <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    trk_interval = v;
  endtask

  // The reset interval is in effect before any write. The very first poll
  // only primes the phase, but its tick still counts toward the flush.
  task automatic test_reset_interval();
    int i;
    sender_idles = 1'b1;
    send_poll(2'b11, 1'b1);
    for (i = 0; i < 19; i++) begin
      send_step(qedr_pkg::STEP_UP, 1'b1);
    end
    send_step(qedr_pkg::STEP_DOWN, 1'b0);
    settle();
  endtask

  // Walks through all sixteen ordered pairs of phases with a flush on every
  // poll, so each step, hold and double-bit jump shows up on its own.
  task automatic test_transitions();
    logic [1:0] walk[$];
    write_interval(qedr_pkg::INTERVAL_WIDTH'(1));
    walk = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
             2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
    foreach (walk[i]) begin
      send_poll(walk[i], 1'b1);
    end
    settle();
  endtask

  // A zero interval, a short one, and an interval lowered below the tick
  // count already reached, which must flush on the next tick.
  task automatic test_interval_edges();
    int i;
    write_interval('0);
    for (i = 0; i < 6; i++) begin
      send_step(($urandom_range(0, 1) != 0) ? qedr_pkg::STEP_UP : qedr_pkg::STEP_DOWN,
                1'b1);
    end
    write_interval(qedr_pkg::INTERVAL_WIDTH'(2));
    for (i = 0; i < 8; i++) begin
      send_step(qedr_pkg::STEP_UP, i[0]);
    end
    write_interval(qedr_pkg::INTERVAL_WIDTH'(100));
    for (i = 0; i < 50; i++) begin
      send_step(qedr_pkg::STEP_DOWN, 1'b1);
    end
    write_interval(qedr_pkg::INTERVAL_WIDTH'(10));
    for (i = 0; i < 3; i++) begin
      send_step(qedr_pkg::STEP_DOWN, 1'b1);
    end
    settle();
  endtask

  // The largest interval the field can hold.
  task automatic test_long_intervals();
    int i;
    sender_idles = 1'b0;
    write_interval('1);
    for (i = 0; i < 1025; i++) begin
      send_step(qedr_pkg::step_t'($urandom_range(0, 2)), 1'b1);
    end
    settle();
  endtask

  // Random phases: mostly clean rotation runs in either direction or holds,
  // with some noise polls that jump anywhere, including double-bit jumps.
  task automatic test_random();
    int phase_idx;
    int sent;
    int run_len;
    int tick_odds;
    int pause_at;
    int pick;
    qedr_pkg::step_t dir;
    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        write_interval(qedr_pkg::INTERVAL_WIDTH'($urandom_range(0, 6)));
      end else if (pick < 9) begin
        write_interval(qedr_pkg::INTERVAL_WIDTH'($urandom_range(7, 40)));
      end else begin
        write_interval(qedr_pkg::FLUSH_RESET);
      end
      // Every third phase runs without sender gaps.
      sender_idles = (phase_idx % 3) != 0;
      tick_odds    = $urandom_range(1, 4);
      pause_at     = $urandom_range(20, POLLS_PER_PHASE - 20);
      sent         = 0;
      while (sent < POLLS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) begin
          dir     = qedr_pkg::step_t'($urandom_range(0, 2));
          run_len = $urandom_range(1, 12);
          repeat (run_len) begin
            send_step(dir, $urandom_range(1, tick_odds) == 1);
            sent++;
          end
        end else begin
          send_poll(2'($urandom_range(0, 3)), $urandom_range(1, tick_odds) == 1);
          sent++;
        end
        // Once per phase the sender waits for the receiver to catch up.
        if (pause_at != 0 && sent >= pause_at) begin
          await_deltas();
          pause_at = 0;
        end
      end
    end
    settle();
  endtask

  // Receiver: out_ready follows a pattern that changes every so often:
  // always ready, a coin toss, sparse ready from a free-running counter, or long stalls.
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      ready_pattern = ready_pattern_t'($urandom_range(0, 3));
      pattern_left  = $urandom_range(16, 128);
    end
    pattern_left--;
    sparse_count++;
    case (ready_pattern)
      RP_ALWAYS: out_ready <= 1'b1;
      RP_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RP_SPARSE: out_ready <= (sparse_count % 4) == 0;
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          hold_left = $urandom_range(5, MAX_STALL);
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // Checker: each delta transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_deltas.size() == 0) begin
        report_mismatch($sformatf("unexpected delta %0d", delta));
      end else begin
        expected_delta = pending_deltas.pop_front();
        if (delta !== expected_delta) begin
          report_mismatch($sformatf("delta %0d, expected %0d", delta, expected_delta));
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_interval();
    test_transitions();
    test_interval_edges();
    test_long_intervals();
    test_random();
    settle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
